// ===== hw/rtl/aap_pkg.sv =====
// shared types, constants and the control program of the aim angle predictor
package aap_pkg;

    localparam int FRAC_BITS = 16;
    localparam int GAIN_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int GAIN_W    = 16;
    localparam int LIM_W     = 31;
    localparam int MUL_W     = DATA_W + 1;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int STEP_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int S_DATA_W  = 96;
    localparam int MEAS_LSB  = 0;
    localparam int HZ_LSB    = MEAS_LSB + DATA_W;
    localparam int REF_LSB   = HZ_LSB + LIM_W;

    localparam logic [GAIN_W-1:0] POS_GAIN_RST = 16'd9830;
    localparam logic [GAIN_W-1:0] VEL_GAIN_RST = 16'd6554;
    localparam logic [GAIN_W-1:0] ACC_GAIN_RST = 16'd46334;
    localparam logic [GAIN_W-1:0] SMOOTH_RST   = 16'd655;
    localparam logic [LIM_W-1:0]  VEL_LIMIT_RST =
        LIM_W'(((64'd6 << FRAC_BITS) + 64'd10) / 64'd20);
    localparam logic [LIM_W-1:0]  WARMUP_RST = LIM_W'(64'd10 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POS_GAIN  = 3'd0,
        CFG_VEL_GAIN  = 3'd1,
        CFG_ACC_GAIN  = 3'd2,
        CFG_SMOOTH    = 3'd3,
        CFG_VEL_LIMIT = 3'd4,
        CFG_WARMUP    = 3'd5
    } cfg_idx_t;

    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef struct packed {
        logic [GAIN_W-1:0] pos_gain;
        logic [GAIN_W-1:0] vel_gain;
        logic [GAIN_W-1:0] acc_gain;
        logic [GAIN_W-1:0] smooth;
        logic [LIM_W-1:0]  vel_limit;
        logic [LIM_W-1:0]  warmup;
    } cfg_t;

    // adder operand sources
    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_MEAS,
        SRC_PRIOR,
        SRC_P,
        SRC_VEL,
        SRC_GV,
        SRC_ACC,
        SRC_SA,
        SRC_SA_HALF,
        SRC_MRES,
        SRC_TV,
        SRC_TTA_HALF
    } src_t;

    typedef enum logic [3:0] {
        DST_NONE,
        DST_D,
        DST_P,
        DST_GV,
        DST_ACC,
        DST_SA,
        DST_PRIOR,
        DST_VEL,
        DST_TV,
        DST_TT,
        DST_TTA,
        DST_OUT
    } dst_t;

    typedef enum logic [1:0] {
        MA_D,
        MA_T,
        MA_TT
    } ma_t;

    typedef enum logic [2:0] {
        MB_POS_GAIN,
        MB_VEL_GAIN,
        MB_ACC_GAIN,
        MB_SMOOTH,
        MB_GV,
        MB_T,
        MB_SA
    } mb_t;

    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_BR_CLEAR,
        SEQ_END
    } seq_t;

    typedef struct packed {
        src_t              alu_a;
        src_t              alu_b;
        src_t              alu_c;    // subtracted; for the new prior and the output a third term is added instead
        dst_t              alu_dst;
        logic              mul_en;
        ma_t               mul_a;
        mb_t               mul_b;
        logic              mul_frac; // product scaled by FRAC_BITS, else GAIN_BITS
        logic              pre;      // first-update load and elapsed time advance
        logic              tstep;    // pick the extrapolation step
        logic              clamp;    // velocity limit
        logic              clear;
        seq_t              seq;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    localparam ctrl_t CTRL_NOP = '{
        alu_a:    SRC_ZERO,
        alu_b:    SRC_ZERO,
        alu_c:    SRC_ZERO,
        alu_dst:  DST_NONE,
        mul_en:   1'b0,
        mul_a:    MA_D,
        mul_b:    MB_POS_GAIN,
        mul_frac: 1'b0,
        pre:      1'b0,
        tstep:    1'b0,
        clamp:    1'b0,
        clear:    1'b0,
        seq:      SEQ_NEXT,
        target:   '0
    };

    localparam logic [STEP_W-1:0] STEP_CLEAR = 5'd20;

    // control program, one word per step
    function automatic ctrl_t prog_word(input logic [STEP_W-1:0] step);
        ctrl_t w;
        w = CTRL_NOP;
        case (step)
            5'd0:
            begin
                w.seq    = SEQ_BR_CLEAR;
                w.target = STEP_CLEAR;
            end
            5'd1:
            begin
                w.pre = 1'b1;
            end
            5'd2:
            begin
                w.tstep   = 1'b1;
                w.alu_a   = SRC_MEAS;
                w.alu_c   = SRC_PRIOR;
                w.alu_dst = DST_D;
            end
            5'd3:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_D;
                w.mul_b  = MB_POS_GAIN;
            end
            5'd4:
            begin
                w.alu_a   = SRC_PRIOR;
                w.alu_b   = SRC_MRES;
                w.alu_dst = DST_P;
            end
            5'd5:
            begin
                w.alu_a   = SRC_P;
                w.alu_c   = SRC_PRIOR;
                w.alu_dst = DST_D;
            end
            5'd6:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_D;
                w.mul_b  = MB_VEL_GAIN;
            end
            5'd7:
            begin
                w.alu_a   = SRC_VEL;
                w.alu_b   = SRC_MRES;
                w.alu_dst = DST_GV;
            end
            5'd8:
            begin
                w.alu_a   = SRC_GV;
                w.alu_c   = SRC_VEL;
                w.alu_dst = DST_D;
            end
            5'd9:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_D;
                w.mul_b  = MB_ACC_GAIN;
            end
            5'd10:
            begin
                w.alu_b   = SRC_MRES;
                w.alu_dst = DST_ACC;
            end
            5'd11:
            begin
                w.alu_a   = SRC_ACC;
                w.alu_c   = SRC_SA;
                w.alu_dst = DST_D;
            end
            5'd12:
            begin
                w.mul_en = 1'b1;
                w.mul_a  = MA_D;
                w.mul_b  = MB_SMOOTH;
            end
            5'd13:
            begin
                w.alu_a   = SRC_SA;
                w.alu_b   = SRC_MRES;
                w.alu_dst = DST_SA;
                w.clamp   = 1'b1;
            end
            5'd14:
            begin
                w.alu_a    = SRC_P;
                w.alu_b    = SRC_GV;
                w.alu_c    = SRC_ZERO;
                w.alu_dst  = DST_PRIOR;
                w.mul_en   = 1'b1;
                w.mul_a    = MA_T;
                w.mul_b    = MB_GV;
                w.mul_frac = 1'b1;
            end
            5'd15:
            begin
                w.alu_b    = SRC_MRES;
                w.alu_dst  = DST_TV;
                w.mul_en   = 1'b1;
                w.mul_a    = MA_T;
                w.mul_b    = MB_T;
                w.mul_frac = 1'b1;
            end
            5'd16:
            begin
                w.alu_b   = SRC_MRES;
                w.alu_dst = DST_TT;
            end
            5'd17:
            begin
                w.alu_a    = SRC_GV;
                w.alu_b    = SRC_SA;
                w.alu_c    = SRC_ACC;
                w.alu_dst  = DST_VEL;
                w.mul_en   = 1'b1;
                w.mul_a    = MA_TT;
                w.mul_b    = MB_SA;
                w.mul_frac = 1'b1;
            end
            5'd18:
            begin
                w.alu_b   = SRC_MRES;
                w.alu_dst = DST_TTA;
            end
            5'd19:
            begin
                w.alu_a   = SRC_P;
                w.alu_b   = SRC_TV;
                w.alu_c   = SRC_ZERO;
                w.alu_dst = DST_OUT;
                w.seq     = SEQ_END;
            end
            STEP_CLEAR:
            begin
                w.clear   = 1'b1;
                w.alu_dst = DST_OUT;
                w.seq     = SEQ_END;
            end
            default:
            begin
                w.seq = SEQ_END;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/aap_sequencer.sv =====
// step counter and control program sequencer
module aap_sequencer import aap_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  op_t   start_op,
    input  logic  out_free,
    output logic  busy,
    output logic  done,
    output ctrl_t ctrl
);

    logic              busy_reg;
    logic              busy_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    op_t               op_reg;
    op_t               op_next;
    ctrl_t             word;
    logic              stall;
    logic              run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
            op_reg   <= OP_UPDATE;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            op_reg   <= op_next;
        end
    end

    always_comb
    begin
        word  = prog_word(step_reg);
        // last step waits until the output register can take the result
        stall = (word.seq == SEQ_END) && !out_free;
        run   = busy_reg && !stall;
        ctrl  = run ? word : CTRL_NOP;
        done  = run && (word.seq == SEQ_END);

        busy_next = busy_reg;
        step_next = step_reg;
        op_next   = op_reg;
        if (run)
        begin
            unique case (word.seq)
                SEQ_NEXT:
                begin
                    step_next = step_reg + 1'b1;
                end
                SEQ_BR_CLEAR:
                begin
                    step_next = (op_reg == OP_CLEAR) ? word.target : step_reg + 1'b1;
                end
                SEQ_END:
                begin
                    busy_next = 1'b0;
                end
                default:
                begin
                    busy_next = 1'b0;
                end
            endcase
        end
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            op_next   = start_op;
        end
    end

    assign busy = busy_reg;

endmodule

// ===== hw/rtl/aap_datapath.sv =====
// tracking state, shared adder with saturation and shared multiplier
module aap_datapath import aap_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [DATA_W-1:0] meas_in,
    input  logic [LIM_W-1:0]  horizon_in,
    input  logic [DATA_W-1:0] ref_in,
    input  cfg_t              cfg,
    input  ctrl_t             ctrl,
    output logic [DATA_W-1:0] result
);

    typedef struct packed {
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] prior;
        logic signed [DATA_W-1:0] p;
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] gv;
        logic signed [DATA_W-1:0] acc;
        logic signed [DATA_W-1:0] sa;
        logic signed [DATA_W-1:0] sa_half;
        logic signed [DATA_W-1:0] mres;
        logic signed [DATA_W-1:0] tv;
        logic signed [DATA_W-1:0] tta_half;
    } srcs_t;

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [DATA_W+1:0] v);
        logic signed [DATA_W-1:0] r;
        if (&v[DATA_W+1:DATA_W-1] || ~|v[DATA_W+1:DATA_W-1])
            r = v[DATA_W-1:0];
        else
            r = v[DATA_W+1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat_prod(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (&v[PROD_W-1:DATA_W-1] || ~|v[PROD_W-1:DATA_W-1])
            r = v[DATA_W-1:0];
        else
            r = v[PROD_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        return r;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick(input src_t s, input srcs_t v);
        logic signed [DATA_W-1:0] r;
        case (s)
            SRC_MEAS:     r = v.meas;
            SRC_PRIOR:    r = v.prior;
            SRC_P:        r = v.p;
            SRC_VEL:      r = v.vel;
            SRC_GV:       r = v.gv;
            SRC_ACC:      r = v.acc;
            SRC_SA:       r = v.sa;
            SRC_SA_HALF:  r = v.sa_half;
            SRC_MRES:     r = v.mres;
            SRC_TV:       r = v.tv;
            SRC_TTA_HALF: r = v.tta_half;
            default:      r = '0;
        endcase
        return r;
    endfunction

    logic signed [DATA_W-1:0] meas_reg;
    logic        [LIM_W-1:0]  hz_reg;
    logic signed [DATA_W-1:0] ref_reg;
    logic        [DATA_W-1:0] elapsed_reg;
    logic signed [DATA_W-1:0] prior_reg;
    logic signed [DATA_W-1:0] vel_reg;
    logic signed [DATA_W-1:0] sa_reg;
    logic signed [DATA_W-1:0] p_reg;
    logic signed [DATA_W-1:0] gv_reg;
    logic signed [DATA_W-1:0] acc_reg;
    logic signed [DATA_W-1:0] tv_reg;
    logic signed [DATA_W-1:0] tt_reg;
    logic signed [DATA_W-1:0] tta_reg;
    logic        [LIM_W-1:0]  t_reg;
    logic signed [DATA_W:0]   d_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     frac_reg;
    logic signed [DATA_W-1:0] out_reg;

    srcs_t                    srcs;
    logic signed [PROD_W-1:0] prod_shifted;
    logic signed [DATA_W-1:0] mres;
    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic signed [DATA_W-1:0] op_c;
    logic signed [DATA_W+1:0] sum;
    logic signed [DATA_W-1:0] alu_res;
    logic        [DATA_W:0]   el_sum;
    logic        [DATA_W-1:0] el_next;
    logic        [LIM_W-1:0]  t_next;
    logic signed [DATA_W-1:0] lim_pos;
    logic signed [DATA_W-1:0] lim_neg;
    logic signed [DATA_W-1:0] gv_clamped;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;

    always_comb
    begin
        prod_shifted = frac_reg ? (prod_reg >>> FRAC_BITS) : (prod_reg >>> GAIN_BITS);
        mres         = sat_prod(prod_shifted);

        srcs.meas     = meas_reg;
        srcs.prior    = prior_reg;
        srcs.p        = p_reg;
        srcs.vel      = vel_reg;
        srcs.gv       = gv_reg;
        srcs.acc      = acc_reg;
        srcs.sa       = sa_reg;
        srcs.sa_half  = sa_reg >>> 1;
        srcs.mres     = mres;
        srcs.tv       = tv_reg;
        srcs.tta_half = tta_reg >>> 1;

        op_a = pick(ctrl.alu_a, srcs);
        op_b = pick(ctrl.alu_b, srcs);
        op_c = pick(ctrl.alu_c, srcs);
        // third term of the new prior and of the output rides on the c slot as an add
        if (ctrl.alu_dst == DST_PRIOR)
            sum = (DATA_W+2)'(op_a) + (DATA_W+2)'(op_b) + (DATA_W+2)'(srcs.sa_half);
        else if (ctrl.alu_dst == DST_OUT && !ctrl.clear)
            sum = (DATA_W+2)'(op_a) + (DATA_W+2)'(op_b) + (DATA_W+2)'(srcs.tta_half);
        else
            sum = (DATA_W+2)'(op_a) + (DATA_W+2)'(op_b) - (DATA_W+2)'(op_c);
        alu_res = sat_sum(sum);

        el_sum  = {1'b0, elapsed_reg} + (DATA_W+1)'(hz_reg);
        el_next = el_sum[DATA_W] ? '1 : el_sum[DATA_W-1:0];
        t_next  = (elapsed_reg < DATA_W'(cfg.warmup)) ? '0 : hz_reg;

        lim_pos = {1'b0, cfg.vel_limit};
        lim_neg = -lim_pos;
        if (gv_reg > lim_pos)
            gv_clamped = lim_pos;
        else if (gv_reg < lim_neg)
            gv_clamped = lim_neg;
        else
            gv_clamped = gv_reg;

        case (ctrl.mul_a)
            MA_D:    mul_a = d_reg;
            MA_T:    mul_a = {2'b00, t_reg};
            MA_TT:   mul_a = MUL_W'(tt_reg);
            default: mul_a = '0;
        endcase
        case (ctrl.mul_b)
            MB_POS_GAIN: mul_b = {{(MUL_W-GAIN_W){1'b0}}, cfg.pos_gain};
            MB_VEL_GAIN: mul_b = {{(MUL_W-GAIN_W){1'b0}}, cfg.vel_gain};
            MB_ACC_GAIN: mul_b = {{(MUL_W-GAIN_W){1'b0}}, cfg.acc_gain};
            MB_SMOOTH:   mul_b = {{(MUL_W-GAIN_W){1'b0}}, cfg.smooth};
            MB_GV:       mul_b = MUL_W'(gv_reg);
            MB_T:        mul_b = {2'b00, t_reg};
            MB_SA:       mul_b = MUL_W'(sa_reg);
            default:     mul_b = '0;
        endcase
    end

    // tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            prior_reg   <= '0;
            vel_reg     <= '0;
            sa_reg      <= '0;
        end
        else if (ctrl.clear)
        begin
            elapsed_reg <= '0;
            prior_reg   <= '0;
            vel_reg     <= '0;
            sa_reg      <= '0;
        end
        else
        begin
            if (ctrl.pre)
            begin
                if (elapsed_reg == '0)
                    prior_reg <= ref_reg;
                elapsed_reg <= el_next;
            end
            case (ctrl.alu_dst)
                DST_PRIOR: prior_reg <= alu_res;
                DST_VEL:   vel_reg   <= alu_res;
                DST_SA:    sa_reg    <= alu_res;
                default:   ;
            endcase
        end
    end

    // request payload and working values
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            meas_reg <= meas_in;
            hz_reg   <= horizon_in;
            ref_reg  <= ref_in;
        end
        if (ctrl.tstep)
            t_reg <= t_next;
        case (ctrl.alu_dst)
            DST_D:   d_reg   <= sum[DATA_W:0];
            DST_P:   p_reg   <= alu_res;
            DST_GV:  gv_reg  <= alu_res;
            DST_ACC: acc_reg <= alu_res;
            DST_TV:  tv_reg  <= alu_res;
            DST_TT:  tt_reg  <= alu_res;
            DST_TTA: tta_reg <= alu_res;
            DST_OUT: out_reg <= alu_res;
            default: ;
        endcase
        if (ctrl.clamp)
            gv_reg <= gv_clamped;
        if (ctrl.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
            frac_reg <= ctrl.mul_frac;
        end
    end

    assign result = out_reg;

endmodule

// ===== hw/rtl/aim_angle_predictor.sv =====
// top level of the aim angle predictor: ports, configuration registers, output register
//
// Tracks a target angle with an alpha-beta-gamma predictor in signed Q16.16
// (gains Q0.16) and returns one extrapolated angle per request. A request is
// taken when the block is idle; an update then runs a 20-step control program,
// one step per clock, on one shared 33x33 multiplier and one saturating adder,
// so the result is in the output register when the program ends, and the next
// request is taken only after that. A clear request (tuser high) clears the
// tracking state and puts 0 in the output register. The last step waits while
// the output register still holds an untaken result. Configuration writes are
// always ready and belong to idle periods.
module aim_angle_predictor import aap_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [31:0] measured_angle, [62:32] horizon, [94:63] reference_angle, [95] zero
    input  logic [S_DATA_W-1:0]  s_tdata,
    // [0] op
    input  logic                 s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [31:0] predicted_angle
    output logic [DATA_W-1:0]    m_tdata,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIM_W-1:0]     cfg_data
);

    cfg_t  cfg_reg;
    logic  m_tvalid_reg;
    logic  out_free;
    logic  start;
    logic  busy;
    logic  seq_done;
    ctrl_t ctrl;

    assign cfg_ready = 1'b1;
    assign s_tready  = !busy;
    assign start     = s_tvalid && !busy;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pos_gain  <= POS_GAIN_RST;
            cfg_reg.vel_gain  <= VEL_GAIN_RST;
            cfg_reg.acc_gain  <= ACC_GAIN_RST;
            cfg_reg.smooth    <= SMOOTH_RST;
            cfg_reg.vel_limit <= VEL_LIMIT_RST;
            cfg_reg.warmup    <= WARMUP_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_POS_GAIN:  cfg_reg.pos_gain  <= cfg_data[GAIN_W-1:0];
                CFG_VEL_GAIN:  cfg_reg.vel_gain  <= cfg_data[GAIN_W-1:0];
                CFG_ACC_GAIN:  cfg_reg.acc_gain  <= cfg_data[GAIN_W-1:0];
                CFG_SMOOTH:    cfg_reg.smooth    <= cfg_data[GAIN_W-1:0];
                CFG_VEL_LIMIT: cfg_reg.vel_limit <= cfg_data;
                CFG_WARMUP:    cfg_reg.warmup    <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (seq_done)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    aap_sequencer u_seq
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .start_op (op_t'(s_tuser)),
        .out_free (out_free),
        .busy     (busy),
        .done     (seq_done),
        .ctrl     (ctrl)
    );

    aap_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (start),
        .meas_in    (s_tdata[MEAS_LSB +: DATA_W]),
        .horizon_in (s_tdata[HZ_LSB +: LIM_W]),
        .ref_in     (s_tdata[REF_LSB +: DATA_W]),
        .cfg        (cfg_reg),
        .ctrl       (ctrl),
        .result     (m_tdata)
    );

    // a result is only finished when the output register can take it
    a_done_slot: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |-> (!m_tvalid_reg || m_tready))
        else $error("result finished while output register full");

    // an accepted request sets the busy register, so no second request is taken behind it
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while previous one still running");

    // every finished result is offered on the next cycle
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        seq_done |=> m_tvalid)
        else $error("finished result not offered");

    // the datapath sees no control while idle
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> (ctrl.alu_dst == DST_NONE && !ctrl.mul_en && !ctrl.clear))
        else $error("datapath driven while idle");

endmodule

// ===== test/aim_angle_predictor_tb.sv =====
// self-checking testbench of the aim angle predictor with a built-in tracking model
`timescale 1ns / 1ps

module aim_angle_predictor_tb;
    import aap_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [DATA_W-1:0] ANGLE_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] ANGLE_MIN = 32'h8000_0000;
    localparam logic [LIM_W-1:0] HZ_MAX = 31'h7FFF_FFFF;

    // tracks the filter state and holds the angles still to come out
    class aim_scoreboard;
        logic [GAIN_W-1:0] pos_gain;
        logic [GAIN_W-1:0] vel_gain;
        logic [GAIN_W-1:0] acc_gain;
        logic [GAIN_W-1:0] smooth;
        logic [LIM_W-1:0] vel_limit;
        logic [LIM_W-1:0] warmup;
        logic [DATA_W-1:0] elapsed;
        int prior;
        int vel;
        int accel;
        logic [DATA_W-1:0] pending_angles[$];
        int errors;

        function new();
            pos_gain  = POS_GAIN_RST;
            vel_gain  = VEL_GAIN_RST;
            acc_gain  = ACC_GAIN_RST;
            smooth    = SMOOTH_RST;
            vel_limit = VEL_LIMIT_RST;
            warmup    = WARMUP_RST;
            errors    = 0;
            clear_state();
        endfunction

        function void clear_state();
            elapsed = '0;
            prior   = 0;
            vel     = 0;
            accel   = 0;
        endfunction

        static function int sat32(longint v);
            if (v > longint'(32'sh7FFF_FFFF))
                return 32'sh7FFF_FFFF;
            if (v < longint'(32'sh8000_0000))
                return 32'sh8000_0000;
            return int'(v);
        endfunction

        // >>> on a signed longint is a floor division by a power of two
        static function int gain_mul(longint x, logic [GAIN_W-1:0] g);
            return sat32((x * longint'(g)) >>> GAIN_BITS);
        endfunction

        static function int q_mul(longint a, longint b);
            return sat32((a * b) >>> FRAC_BITS);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [LIM_W-1:0] data);
            case (idx)
                CFG_POS_GAIN:  pos_gain  = data[GAIN_W-1:0];
                CFG_VEL_GAIN:  vel_gain  = data[GAIN_W-1:0];
                CFG_ACC_GAIN:  acc_gain  = data[GAIN_W-1:0];
                CFG_SMOOTH:    smooth    = data[GAIN_W-1:0];
                CFG_VEL_LIMIT: vel_limit = data;
                CFG_WARMUP:    warmup    = data;
                default:       ;
            endcase
        endfunction

        function void accept_request(op_t op, int meas, logic [LIM_W-1:0] hz, int refa);
            longint sum;
            longint t;
            longint lim;
            int p;
            int gv;
            int acc;
            int sa;
            int tv;
            int tt;
            int tta;
            if (op == OP_CLEAR)
            begin
                clear_state();
                pending_angles.push_back('0);
                return;
            end
            if (elapsed == 0)
                prior = refa;
            sum = longint'(elapsed) + longint'(hz);
            elapsed = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            t = (elapsed < warmup) ? 0 : longint'(hz);

            p   = sat32(longint'(prior) + gain_mul(longint'(meas) - prior, pos_gain));
            gv  = sat32(longint'(vel) + gain_mul(longint'(p) - prior, vel_gain));
            acc = gain_mul(longint'(gv) - vel, acc_gain);
            sa  = sat32(longint'(accel) + gain_mul(longint'(acc) - accel, smooth));
            accel = sa;

            lim = longint'(vel_limit);
            if (gv > lim)
                gv = int'(lim);
            if (gv < -lim)
                gv = int'(-lim);

            prior = sat32(longint'(p) + gv + (longint'(sa) >>> 1));
            vel   = sat32(longint'(gv) - acc + sa);

            tv  = q_mul(t, gv);
            tt  = q_mul(t, t);
            tta = q_mul(tt, sa);
            pending_angles.push_back(sat32(longint'(p) + tv + (longint'(tta) >>> 1)));
        endfunction

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        task check_angle(logic [DATA_W-1:0] got);
            logic [DATA_W-1:0] want;
            if (pending_angles.size() == 0)
                report($sformatf("result %h with no request outstanding", got));
            else
            begin
                want = pending_angles.pop_front();
                if (got !== want)
                    report($sformatf("predicted_angle %h, model gives %h", got, want));
            end
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [DATA_W-1:0]    m_tdata;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIM_W-1:0]     cfg_data;

    aim_scoreboard sb;
    int  cycles;
    int  hold_left;
    bit  src_gaps;
    bit  sink_gaps;
    int  track_angle;

    aim_angle_predictor i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side; a pending hold-off overrides the random stalls
    initial
    begin
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(sink_gaps && $urandom_range(0, 99) < 36);
        end
    end

    // results are checked before the request of the same edge is noted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_angle(m_tdata);
            if (s_tvalid && s_tready)
                sb.accept_request(op_t'(s_tuser), s_tdata[MEAS_LSB +: DATA_W],
                                  s_tdata[HZ_LSB +: LIM_W], s_tdata[REF_LSB +: DATA_W]);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // tvalid stays high after a request so back-to-back requests need no toggle
    task automatic send_item(input op_t op, input logic [DATA_W-1:0] meas,
                             input logic [LIM_W-1:0] hz, input logic [DATA_W-1:0] refa);
        while (src_gaps && $urandom_range(0, 99) < 36)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {1'b0, refa, hz, meas};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending_angles.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [LIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic apply_settings(input logic [LIM_W-1:0] pg, input logic [LIM_W-1:0] vg,
                                  input logic [LIM_W-1:0] ag, input logic [LIM_W-1:0] sg,
                                  input logic [LIM_W-1:0] lim, input logic [LIM_W-1:0] wu,
                                  input bit with_spare);
        write_cfg(CFG_POS_GAIN, pg);
        write_cfg(CFG_VEL_GAIN, vg);
        write_cfg(CFG_ACC_GAIN, ag);
        write_cfg(CFG_SMOOTH, sg);
        write_cfg(CFG_VEL_LIMIT, lim);
        write_cfg(CFG_WARMUP, wu);
        // indexes past the register list must leave everything alone
        if (with_spare)
        begin
            write_cfg(CFG_SPARE_LO, HZ_MAX);
            write_cfg(CFG_SPARE_HI, '0);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic random_settings();
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] wu;
        lim = ($urandom_range(0, 3) == 0) ? LIM_W'($urandom) : LIM_W'($urandom_range(0, 'h40000));
        wu  = ($urandom_range(0, 4) == 0) ? '0 : LIM_W'($urandom_range(0, 'h140000));
        apply_settings(LIM_W'($urandom), LIM_W'($urandom), LIM_W'($urandom),
                       LIM_W'($urandom), lim, wu, 1'b0);
    endtask

    // mostly tracking runs of a slowly moving target, with clears and raw noise
    task automatic run_random(input int count);
        int pick;
        logic [LIM_W-1:0] hz;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 7)
            begin
                send_item(OP_CLEAR, $urandom, LIM_W'($urandom), $urandom);
                track_angle = int'($urandom_range(0, 'h200000)) - 'h100000;
            end
            else if (pick < 22)
            begin
                case ($urandom_range(0, 2))
                    0:       hz = '0;
                    1:       hz = LIM_W'($urandom_range(1, 'h40000));
                    default: hz = LIM_W'($urandom);
                endcase
                send_item(OP_UPDATE, $urandom, hz, $urandom);
            end
            else
            begin
                track_angle = track_angle + int'($urandom_range(0, 4000)) - 2000;
                hz = ($urandom_range(0, 3) == 0) ? '0 : LIM_W'($urandom_range(1, 'h20000));
                send_item(OP_UPDATE, track_angle + int'($urandom_range(0, 600)) - 300,
                          hz, track_angle);
            end
        end
    endtask

    initial
    begin
        sb = new();
        cycles      = 0;
        hold_left   = 0;
        src_gaps    = 1'b1;
        sink_gaps   = 1'b1;
        track_angle = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_UPDATE;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_POS_GAIN;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: zero horizon reloads the reference every time
        send_item(OP_UPDATE, ANGLE_MAX, '0, ANGLE_MIN);
        send_item(OP_UPDATE, ANGLE_MIN, '0, ANGLE_MAX);
        send_item(OP_CLEAR, '1, HZ_MAX, '1);
        send_item(OP_UPDATE, 32'h0001_0000, 31'd1, '0);
        for (int k = 1; k <= 8; k++)
            send_item(OP_UPDATE, 32'h0001_0000 * k, 31'h0002_0000, '0);
        // huge horizon overflows the extrapolation, then elapsed time saturates
        send_item(OP_UPDATE, ANGLE_MAX, HZ_MAX, ANGLE_MIN);
        send_item(OP_UPDATE, ANGLE_MAX, HZ_MAX, ANGLE_MIN);
        send_item(OP_UPDATE, ANGLE_MIN, HZ_MAX, ANGLE_MAX);
        send_item(OP_CLEAR, '0, '0, '0);
        wait_idle();

        apply_settings('1, '1, '1, '1, HZ_MAX, '0, 1'b1);
        send_item(OP_UPDATE, ANGLE_MAX, HZ_MAX, ANGLE_MIN);
        send_item(OP_UPDATE, ANGLE_MIN, HZ_MAX, ANGLE_MAX);
        send_item(OP_UPDATE, ANGLE_MAX, 31'd1, '0);
        run_random(40);
        wait_idle();

        apply_settings('0, '0, '0, '0, '0, HZ_MAX, 1'b0);
        run_random(40);
        wait_idle();

        for (int ph = 0; ph < 5; ph++)
        begin
            random_settings();
            src_gaps  = (ph != 1);
            sink_gaps = (ph != 1);
            // long receiver hold-off fills the block and backs up the input
            if (ph == 2)
                hold_left = HOLD_CYCLES;
            run_random(70);
            wait_idle();
        end

        repeat (30) @(posedge clk);
        if (sb.errors == 0 && sb.pending_angles.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== aim_angle_predictor.f =====
hw/rtl/aap_pkg.sv
hw/rtl/aap_sequencer.sv
hw/rtl/aap_datapath.sv
hw/rtl/aim_angle_predictor.sv
test/aim_angle_predictor_tb.sv
